// ----- sv/wfsu_pkg.sv -----
// ----------------------------------------------------------------------------
// wfsu_pkg
// Shared types, register offsets and helper functions of the wavetable FM
// sound unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wfsu_pkg;

  localparam int unsigned WAVE_DEPTH = 64;
  localparam int unsigned MOD_DEPTH  = 32;
  localparam int unsigned WAVE_AW    = $clog2(WAVE_DEPTH);
  localparam int unsigned MOD_AW     = $clog2(MOD_DEPTH);

  // Request types.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Register offsets from the base of the sound window.
  localparam logic [6:0] ADDR_ENV0      = 7'd64;
  localparam logic [6:0] ADDR_FREQ_LO   = 7'd66;
  localparam logic [6:0] ADDR_FREQ_HI   = 7'd67;
  localparam logic [6:0] ADDR_ENV1      = 7'd68;
  localparam logic [6:0] ADDR_SWEEP     = 7'd69;
  localparam logic [6:0] ADDR_MOD_LO    = 7'd70;
  localparam logic [6:0] ADDR_MOD_HI    = 7'd71;
  localparam logic [6:0] ADDR_MOD_PUSH  = 7'd72;
  localparam logic [6:0] ADDR_MASTER    = 7'd73;
  localparam logic [6:0] ADDR_ENV_RATE  = 7'd74;
  localparam logic [6:0] ADDR_STAT_VOL0 = 7'd80;
  localparam logic [6:0] ADDR_STAT_VOL1 = 7'd82;

  // Modulation table code that clears the sweep accumulator.
  localparam logic [2:0] CODE_CLEAR = 3'd4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_MOD,
    CMD_MUL_MOD,
    CMD_FIX,
    CMD_MUL_CAR,
    CMD_CAR,
    CMD_WAVE_RD,
    CMD_MUL_WAVE,
    CMD_WRITE,
    CMD_READ,
    CMD_READ_FORM
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic tog;
    logic mod_off;
  } sts_t;

  function automatic logic signed [3:0] step_of(input logic [2:0] code);
    logic signed [3:0] s;
    case (code)
      3'd0:    s = 4'sd0;
      3'd1:    s = 4'sd1;
      3'd2:    s = 4'sd2;
      3'd3:    s = 4'sd4;
      3'd4:    s = 4'sd0;
      3'd5:    s = -4'sd4;
      3'd6:    s = -4'sd2;
      default: s = -4'sd1;
    endcase
    return s;
  endfunction

  // Output gain: 1536 * min(vol, 32) / (sel + 2). The divide by five uses a
  // reciprocal that is exact over the whole numerator range.
  function automatic logic [14:0] gain_of(input logic [5:0] vol, input logic [1:0] sel);
    logic [5:0]  k;
    logic [15:0] n;
    logic [33:0] p;
    logic [15:0] g;
    k = (vol > 6'd32) ? 6'd32 : vol;
    n = 16'(k) * 16'd1536;
    p = 34'(n) * 34'd52429;
    case (sel)
      2'd0:    g = n >> 1;
      2'd1:    g = 16'(k) * 16'd512;
      2'd2:    g = n >> 2;
      default: g = p[33:18];
    endcase
    return g[14:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/wfsu_if.sv -----
// ----------------------------------------------------------------------------
// wfsu request and response channels
// Valid/ready channels carrying one request and one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wfsu_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] address;
  logic [7:0] write_data;
  logic [7:0] open_bus;

  modport source (output valid, req_type, address, write_data, open_bus, input ready);
  modport sink   (input valid, req_type, address, write_data, open_bus, output ready);
endinterface

interface wfsu_rsp_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  read_data;
  logic signed [12:0] sample;

  modport source (output valid, read_data, sample, input ready);
  modport sink   (input valid, read_data, sample, output ready);
endinterface

`default_nettype wire

// ----- sv/wavetable_fm_sound_unit.sv -----
// ----------------------------------------------------------------------------
// wavetable_fm_sound_unit
// Wavetable sound channel with a frequency modulator, two volume envelopes
// and a 64-entry wave RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req_i: a sound clock tick, a bus write or a bus read.
// Every request yields exactly one result on rsp_o carrying the read byte
// (open bus for ticks and writes) and the current output sample.
// One request is in flight at a time. After acceptance a write runs the
// write step, a read the read and format steps, and a tick the modulator
// update, modulator multiply, wrap fix, carrier multiply, carrier update,
// registered wave RAM read and wave sample multiply, each multiply with a
// register behind it. With the modulator off a tick skips the steps from
// modulator multiply to carrier multiply, and without a sample reload the
// wave sample multiply. The next request can be taken in the cycle after
// the result transaction completes. Reset clears all state registers; the
// wave RAM reads zero until an entry is written. When the receiver stalls
// the result is held and no request is accepted until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_fm_sound_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wfsu_req_if.sink  req_i,
  wfsu_rsp_if.source rsp_o
);

  wfsu_pkg::cmd_t cmd;
  wfsu_pkg::sts_t sts;

  wfsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .req_type_i  (req_i.req_type),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wfsu_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .address_i    (req_i.address),
    .write_data_i (req_i.write_data),
    .open_bus_i   (req_i.open_bus),
    .read_data_o  (rsp_o.read_data),
    .sample_o     (rsp_o.sample)
  );

endmodule

`default_nettype wire

// ----- sv/wfsu_ctrl.sv -----
// ----------------------------------------------------------------------------
// wfsu_ctrl
// Sequencer that walks one request through the datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsu_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [1:0]    req_type_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire wfsu_pkg::sts_t sts_i,
  output wfsu_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_MULM = 4'd2;
  localparam logic [3:0] S_FIX  = 4'd3;
  localparam logic [3:0] S_MULC = 4'd4;
  localparam logic [3:0] S_CAR  = 4'd5;
  localparam logic [3:0] S_WRD  = 4'd6;
  localparam logic [3:0] S_MULW = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_RDF  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.cmd   = wfsu_pkg::CMD_NONE;
    cmd_o.load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (req_type_i)
            wfsu_pkg::REQ_TICK:  state_d = S_MOD;
            wfsu_pkg::REQ_WRITE: state_d = S_WR;
            wfsu_pkg::REQ_READ:  state_d = S_RD;
            default:             state_d = S_OUT;
          endcase
        end
      end
      S_MOD: begin
        cmd_o.cmd = wfsu_pkg::CMD_MOD;
        // With the modulator off the sweep is frozen and the carrier ignores it.
        state_d   = sts_i.mod_off ? S_CAR : S_MULM;
      end
      S_MULM: begin
        cmd_o.cmd = wfsu_pkg::CMD_MUL_MOD;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.cmd = wfsu_pkg::CMD_FIX;
        state_d   = S_MULC;
      end
      S_MULC: begin
        cmd_o.cmd = wfsu_pkg::CMD_MUL_CAR;
        state_d   = S_CAR;
      end
      S_CAR: begin
        cmd_o.cmd = wfsu_pkg::CMD_CAR;
        state_d   = S_WRD;
      end
      S_WRD: begin
        cmd_o.cmd = wfsu_pkg::CMD_WAVE_RD;
        state_d   = sts_i.tog ? S_MULW : S_OUT;
      end
      S_MULW: begin
        cmd_o.cmd = wfsu_pkg::CMD_MUL_WAVE;
        state_d   = S_OUT;
      end
      S_WR: begin
        cmd_o.cmd = wfsu_pkg::CMD_WRITE;
        state_d   = S_OUT;
      end
      S_RD: begin
        cmd_o.cmd = wfsu_pkg::CMD_READ;
        state_d   = S_RDF;
      end
      S_RDF: begin
        cmd_o.cmd = wfsu_pkg::CMD_READ_FORM;
        state_d   = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted request did not start processing");

  a_no_toggle_skips_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRD && !sts_i.tog) |=> (state_q == S_OUT))
    else $error("sample reload without a phase toggle");

  a_mod_off_skips_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && sts_i.mod_off) |=> (state_q == S_CAR))
    else $error("modulator multiply run while modulator is off");

endmodule

`default_nettype wire

// ----- sv/wfsu_datapath.sv -----
// ----------------------------------------------------------------------------
// wfsu_datapath
// Registers, wave RAM, modulation table and arithmetic of the sound unit.
// ----------------------------------------------------------------------------
`default_nettype none

module wfsu_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire wfsu_pkg::cmd_t     cmd_i,
  output wfsu_pkg::sts_t          sts_o,
  input  wire logic [6:0]         address_i,
  input  wire logic [7:0]         write_data_i,
  input  wire logic [7:0]         open_bus_i,
  output logic [7:0]              read_data_o,
  output logic signed [12:0]      sample_o
);

  localparam int unsigned WA = wfsu_pkg::WAVE_AW;

  // Request payload.
  logic [6:0] addr_q, addr_d;
  logic [7:0] wdata_q, wdata_d;
  logic [7:0] obus_q, obus_d;
  logic [7:0] rdata_q, rdata_d;

  // Architectural state.
  logic [11:0] cf_q, cf_d;
  logic [27:0] cph_q, cph_d;
  logic [1:0]  cc_q, cc_d;
  logic [11:0] mf_q, mf_d;
  logic [21:0] mph_q, mph_d;
  logic        mod_off_q, mod_off_d;
  logic [7:0]  mc_q, mc_d;
  logic [7:0]  erate_q, erate_d;
  logic [10:0] epre_q, epre_d;
  logic [7:0]  ectl_q [2];
  logic [7:0]  ectl_d [2];
  logic [5:0]  vol_q [2];
  logic [5:0]  vol_d [2];
  logic [6:0]  cnt_q [2];
  logic [6:0]  cnt_d [2];
  logic [2:0]  mtab_q [wfsu_pkg::MOD_DEPTH];
  logic [2:0]  mtab_d [wfsu_pkg::MOD_DEPTH];
  logic [wfsu_pkg::WAVE_DEPTH-1:0] wvalid_q, wvalid_d;
  logic [10:0] sweep_q, sweep_d;
  logic [14:0] gain_q;
  logic signed [8:0]  mamt_q, mamt_d;
  logic signed [12:0] samp_q, samp_d;

  // Intermediate results.
  logic signed [16:0] prodm_q, prodm_d;
  logic signed [21:0] prodc_q, prodc_d;
  logic               tog_q, tog_d;

  // Wave RAM.
  logic [5:0]    wave_mem [wfsu_pkg::WAVE_DEPTH];
  logic [5:0]    wrd_raw_q;
  logic          wrd_valid_q;
  logic [WA-1:0] wave_raddr;
  logic          wave_we;
  logic [5:0]    wave_rd;

  // Combinational terms.
  logic [21:0]        mph_sum;
  logic [2:0]         mod_code;
  logic [10:0]        sweep_step;
  logic [5:0]         k1;
  logic signed [16:0] mul_m;
  logic               round_up;
  logic signed [10:0] fix0, fix1, fix2, fix3;
  logic signed [21:0] mul_c;
  logic signed [22:0] car_f;
  logic [21:0]        car_step;
  logic [27:0]        cph_new;
  logic               car_en;
  logic signed [6:0]  wv;
  logic signed [22:0] mul_w;

  assign wave_rd    = wrd_valid_q ? wrd_raw_q : 6'd0;
  assign wave_raddr = (cmd_i.cmd == wfsu_pkg::CMD_WAVE_RD) ? cph_q[27:22] : addr_q[WA-1:0];
  assign wave_we    = (cmd_i.cmd == wfsu_pkg::CMD_WRITE) && !addr_q[6] && mc_q[7];

  always_ff @(posedge clk_i) begin
    if (wave_we) begin
      wave_mem[addr_q[WA-1:0]] <= wdata_q[5:0];
    end
    wrd_raw_q <= wave_mem[wave_raddr];
  end

  // Modulator terms.
  assign mph_sum    = mph_q + {10'd0, mf_q};
  assign mod_code   = mtab_q[mph_sum[21:17]];
  assign sweep_step = sweep_q + 11'(wfsu_pkg::step_of(mod_code));
  assign k1         = (vol_q[1] > 6'd32) ? 6'd32 : vol_q[1];
  assign mul_m      = 17'(signed'(sweep_q)) * 17'(signed'({1'b0, k1}));

  // Division by 256 truncates toward zero, then the wrap fixes follow.
  assign round_up = prodm_q[16] && (prodm_q[7:0] != 8'd0);
  always_comb begin
    fix0 = signed'({{2{prodm_q[16]}}, prodm_q[16:8]}) + signed'({10'd0, round_up});
    if (prodm_q[7:4] != 4'd0) begin
      fix1 = sweep_q[10] ? (fix0 - 11'sd1) : (fix0 + 11'sd2);
    end else begin
      fix1 = fix0;
    end
    fix2 = (fix1 >= 11'sd194) ? (fix1 - 11'sd258) : fix1;
    fix3 = (fix2 < -11'sd64) ? (fix2 + 11'sd256) : fix2;
  end

  // Carrier terms.
  assign mul_c    = 22'(signed'({1'b0, cf_q})) * 22'(mamt_q);
  assign car_f    = 23'(signed'({1'b0, cf_q, 6'd0})) + (mod_off_q ? 23'sd0 : 23'(prodc_q));
  assign car_step = (!mod_off_q && car_f[22]) ? 22'd0 : car_f[21:0];
  assign cph_new  = cph_q + {6'd0, car_step};
  assign car_en   = !mc_q[7] && !cc_q[1];

  // Sample terms.
  assign wv    = signed'({1'b0, wave_rd}) - 7'sd32;
  assign mul_w = 23'(wv) * 23'(signed'({1'b0, gain_q}));

  always_comb begin
    addr_d    = addr_q;
    wdata_d   = wdata_q;
    obus_d    = obus_q;
    rdata_d   = rdata_q;
    cf_d      = cf_q;
    cph_d     = cph_q;
    cc_d      = cc_q;
    mf_d      = mf_q;
    mph_d     = mph_q;
    mod_off_d = mod_off_q;
    mc_d      = mc_q;
    erate_d   = erate_q;
    epre_d    = epre_q;
    ectl_d    = ectl_q;
    vol_d     = vol_q;
    cnt_d     = cnt_q;
    mtab_d    = mtab_q;
    wvalid_d  = wvalid_q;
    sweep_d   = sweep_q;
    mamt_d    = mamt_q;
    samp_d    = samp_q;
    prodm_d   = prodm_q;
    prodc_d   = prodc_q;
    tog_d     = tog_q;

    unique case (cmd_i.cmd)
      wfsu_pkg::CMD_MOD: begin
        if (!mod_off_q) begin
          mph_d = mph_sum;
          if ((mph_sum[17:12] ^ mph_q[17:12]) != 6'd0) begin
            sweep_d = (mod_code == wfsu_pkg::CODE_CLEAR) ? 11'd0 : sweep_step;
          end
        end
      end
      wfsu_pkg::CMD_MUL_MOD: prodm_d = mul_m;
      wfsu_pkg::CMD_FIX:     mamt_d  = fix3[8:0];
      wfsu_pkg::CMD_MUL_CAR: prodc_d = mul_c;
      wfsu_pkg::CMD_CAR: begin
        if (car_en) begin
          cph_d = cph_new;
        end
        tog_d = car_en && (cph_new[22] ^ cph_q[22]);
        if (erate_q != 8'd0) begin
          if (epre_q <= 11'd1) begin
            epre_d = {erate_q, 3'd0};
            for (int x = 0; x < 2; x++) begin
              if (!ectl_q[x][7] && !cc_q[0]) begin
                if (cnt_q[x] <= 7'd1) begin
                  if (ectl_q[x][6]) begin
                    if (vol_q[x] < 6'd32) begin
                      vol_d[x] = vol_q[x] + 6'd1;
                    end
                  end else if (vol_q[x] != 6'd0) begin
                    vol_d[x] = vol_q[x] - 6'd1;
                  end
                  cnt_d[x] = {1'b0, ectl_q[x][5:0]} + 7'd1;
                end else begin
                  cnt_d[x] = cnt_q[x] - 7'd1;
                end
              end
            end
          end else begin
            epre_d = epre_q - 11'd1;
          end
        end
      end
      wfsu_pkg::CMD_MUL_WAVE: samp_d = mul_w[20:8];
      wfsu_pkg::CMD_WRITE: begin
        if (!addr_q[6]) begin
          if (mc_q[7]) begin
            wvalid_d[addr_q[WA-1:0]] = 1'b1;
          end
        end else begin
          unique case (addr_q)
            wfsu_pkg::ADDR_ENV0: begin
              if (wdata_q[7]) begin
                vol_d[0] = wdata_q[5:0];
              end else if (ectl_q[0][7]) begin
                cnt_d[0] = {1'b0, wdata_q[5:0]} + 7'd1;
              end
              ectl_d[0] = wdata_q;
            end
            wfsu_pkg::ADDR_FREQ_LO: cf_d[7:0] = wdata_q;
            wfsu_pkg::ADDR_FREQ_HI: begin
              if (!wdata_q[7] && cc_q[1]) begin
                cph_d = 28'd0;
              end
              cf_d[11:8] = wdata_q[3:0];
              cc_d       = wdata_q[7:6];
            end
            wfsu_pkg::ADDR_ENV1: begin
              if (wdata_q[7]) begin
                vol_d[1] = wdata_q[5:0];
              end else if (ectl_q[1][7]) begin
                cnt_d[1] = {1'b0, wdata_q[5:0]} + 7'd1;
              end
              ectl_d[1] = wdata_q;
            end
            wfsu_pkg::ADDR_SWEEP: begin
              sweep_d = {wdata_q[6:0], 4'd0};
              mph_d   = 22'd0;
            end
            wfsu_pkg::ADDR_MOD_LO: mf_d[7:0] = wdata_q;
            wfsu_pkg::ADDR_MOD_HI: begin
              mf_d[11:8] = wdata_q[3:0];
              mod_off_d  = wdata_q[7];
            end
            wfsu_pkg::ADDR_MOD_PUSH: begin
              if (mod_off_q) begin
                for (int i = 0; i < wfsu_pkg::MOD_DEPTH - 1; i++) begin
                  mtab_d[i] = mtab_q[i+1];
                end
                mtab_d[wfsu_pkg::MOD_DEPTH-1] = wdata_q[2:0];
              end
            end
            wfsu_pkg::ADDR_MASTER:   mc_d    = wdata_q;
            wfsu_pkg::ADDR_ENV_RATE: erate_d = wdata_q;
            default: ;
          endcase
        end
      end
      wfsu_pkg::CMD_READ_FORM: begin
        if (!addr_q[6]) begin
          rdata_d = mc_q[7] ? {obus_q[7:6], wave_rd} : obus_q;
        end else if (addr_q == wfsu_pkg::ADDR_STAT_VOL0) begin
          rdata_d = {obus_q[7:6], vol_q[0]};
        end else if (addr_q == wfsu_pkg::ADDR_STAT_VOL1) begin
          rdata_d = {obus_q[7:6], vol_q[1]};
        end else begin
          rdata_d = obus_q;
        end
      end
      default: ;
    endcase

    if (cmd_i.load) begin
      addr_d  = address_i;
      wdata_d = write_data_i;
      obus_d  = open_bus_i;
      rdata_d = open_bus_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    wdata_q <= wdata_d;
    obus_q  <= obus_d;
    rdata_q <= rdata_d;
    prodm_q <= prodm_d;
    prodc_q <= prodc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q        <= '0;
      cph_q       <= '0;
      cc_q        <= '0;
      mf_q        <= '0;
      mph_q       <= '0;
      mod_off_q   <= 1'b0;
      mc_q        <= '0;
      erate_q     <= '0;
      epre_q      <= '0;
      ectl_q      <= '{default: '0};
      vol_q       <= '{default: '0};
      cnt_q       <= '{default: '0};
      mtab_q      <= '{default: '0};
      wvalid_q    <= '0;
      sweep_q     <= '0;
      gain_q      <= '0;
      mamt_q      <= '0;
      samp_q      <= '0;
      tog_q       <= 1'b0;
      wrd_valid_q <= 1'b0;
    end else begin
      cf_q        <= cf_d;
      cph_q       <= cph_d;
      cc_q        <= cc_d;
      mf_q        <= mf_d;
      mph_q       <= mph_d;
      mod_off_q   <= mod_off_d;
      mc_q        <= mc_d;
      erate_q     <= erate_d;
      epre_q      <= epre_d;
      ectl_q      <= ectl_d;
      vol_q       <= vol_d;
      cnt_q       <= cnt_d;
      mtab_q      <= mtab_d;
      wvalid_q    <= wvalid_d;
      sweep_q     <= sweep_d;
      // The gain is registered from volume 0 and the master divider.
      gain_q      <= wfsu_pkg::gain_of(vol_q[0], mc_q[1:0]);
      mamt_q      <= mamt_d;
      samp_q      <= samp_d;
      tog_q       <= tog_d;
      wrd_valid_q <= wvalid_q[wave_raddr];
    end
  end

  assign sts_o.tog     = tog_q;
  assign sts_o.mod_off = mod_off_q;
  assign read_data_o   = rdata_q;
  assign sample_o      = samp_q;

endmodule

`default_nettype wire
